@@ src/ppl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ppl_pkg;

  // default coordinate width, Q11.4
  localparam int COORD_BITS_DEF = 16;

  localparam int FIELD_W = 16;
  localparam int SEG_W   = 17;
  localparam int TOT_W   = 32;

  localparam logic [SEG_W-1:0] SEG_MAX   = '1;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic [SEG_W-1:0] segment_length;
    logic [TOT_W-1:0] total_length;
    logic             set_done;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQX,
    ST_SQY,
    ST_ADD,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ src/polyline_path_length.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Polyline path length over a stream of 2-D points (signed Q11.4 by default).
//
// Point channel (pt_valid / pt_stall / pt): a transfer happens at a rising
// edge with pt_valid high and pt_stall low. pt_stall is high whenever the
// block is busy with a point, so one point is worked on at a time.
// Result channel (res_valid / res_stall / res): one result per point after
// the first of a set, and one all-zero result for a one-point set. The
// result sits in an output register and holds while res_stall is high; the
// next point is still taken meanwhile and waits only at its final step.
//
// Sequence: a first point is only stored (ST_LOAD) before the next one is
// taken, and a one-point set passes ST_LOAD and ST_EMIT. Any other point
// passes ST_LOAD, ST_SQX, ST_SQY, ST_ADD, ST_ROOT and ST_EMIT; ST_ROOT waits
// for the bit-serial square root, which delivers one root bit per cycle over
// COORD_BITS+1 bits. One shared multiplier squares dx and then dy on successive cycles.
//
// Reset (rst, synchronous): no point held, total cleared, result channel
// empty. The running total saturates at all ones.
module polyline_path_length #(
  parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pt_valid,
  output logic                  pt_stall,
  input  wire ppl_pkg::point_t  pt,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output ppl_pkg::result_t      res
);

  localparam int CB    = COORD_BITS;
  localparam int RB    = CB + 1;                 // |dx|, |dy| and root width
  localparam int SQ_W  = 2 * RB;                 // sum of squares
  localparam int SEG_W = ppl_pkg::SEG_W;
  localparam int TOT_W = ppl_pkg::TOT_W;
  localparam int AW    = (RB > SEG_W) ? RB : SEG_W;
  localparam int SUM_W = ((RB > TOT_W) ? RB : TOT_W) + 1;

  ppl_pkg::state_t state, state_next;

  // captured point
  logic [CB-1:0] x_r, y_r;
  logic          last_r;

  // set state
  logic [CB-1:0]    prev_x, prev_y;
  logic             have_prev;
  logic [TOT_W-1:0] total;
  logic             one_pt;

  // datapath
  logic [RB-1:0]   dx, dy;
  logic [RB-1:0]   mul_op;
  logic [SQ_W-1:0] mul_res;
  logic [SQ_W-1:0] prod, sumsq;
  logic [SQ_W-1:0] rad_in;

  logic            sq_start, sq_done;
  logic [RB-1:0]   root;

  logic [RB-1:0]   dxs, dys;
  logic [AW-1:0]   seg_ext;
  logic [SEG_W-1:0] seg_sat;
  logic [SUM_W-1:0] sum_wide;
  logic [TOT_W-1:0] sum_sat;
  logic            emit_fire;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ppl_pkg::ST_IDLE: if (pt_valid) state_next = ppl_pkg::ST_LOAD;
      ppl_pkg::ST_LOAD: begin
        if (have_prev) begin
          state_next = ppl_pkg::ST_SQX;
        end else if (last_r) begin
          state_next = ppl_pkg::ST_EMIT;    // one-point set
        end else begin
          state_next = ppl_pkg::ST_IDLE;    // first point only stored
        end
      end
      ppl_pkg::ST_SQX:  state_next = ppl_pkg::ST_SQY;
      ppl_pkg::ST_SQY:  state_next = ppl_pkg::ST_ADD;
      ppl_pkg::ST_ADD:  state_next = ppl_pkg::ST_ROOT;
      ppl_pkg::ST_ROOT: if (sq_done) state_next = ppl_pkg::ST_EMIT;
      ppl_pkg::ST_EMIT: if (emit_fire) state_next = ppl_pkg::ST_IDLE;
      default:          state_next = ppl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pt_stall  = (state != ppl_pkg::ST_IDLE);
    sq_start  = (state == ppl_pkg::ST_ADD);
    emit_fire = (state == ppl_pkg::ST_EMIT) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Differences, shared squarer, accumulate
  // ---------------------------------------------------------------------------
  assign dxs = {x_r[CB-1], x_r} - {prev_x[CB-1], prev_x};
  assign dys = {y_r[CB-1], y_r} - {prev_y[CB-1], prev_y};

  assign mul_op  = (state == ppl_pkg::ST_SQX) ? dx : dy;
  assign mul_res = mul_op * mul_op;
  assign rad_in  = sumsq + prod;

  always_ff @(posedge clk) begin
    if (pt_valid && !pt_stall) begin
      // raw field bits, extended or cut to the coordinate width
      x_r    <= CB'($unsigned(pt.x_coord));
      y_r    <= CB'($unsigned(pt.y_coord));
      last_r <= pt.last_point;
    end
    if (state == ppl_pkg::ST_LOAD) begin
      dx <= dxs[CB] ? (RB'(0) - dxs) : dxs;
      dy <= dys[CB] ? (RB'(0) - dys) : dys;
    end
    if (state == ppl_pkg::ST_SQX || state == ppl_pkg::ST_SQY) begin
      prod <= mul_res;
    end
    if (state == ppl_pkg::ST_SQY) begin
      sumsq <= prod;                          // dx squared
    end
  end

  ppl_sqrt #(
    .ROOT_BITS (RB)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad_in),
    .done     (sq_done),
    .root     (root)
  );

  // segment field saturates only for coordinates wider than 16 bits
  assign seg_ext  = AW'(root);
  assign seg_sat  = (seg_ext > AW'(ppl_pkg::SEG_MAX)) ? ppl_pkg::SEG_MAX
                                                      : seg_ext[SEG_W-1:0];
  assign sum_wide = SUM_W'(total) + SUM_W'(root);
  assign sum_sat  = (sum_wide > SUM_W'(ppl_pkg::TOTAL_MAX)) ? ppl_pkg::TOTAL_MAX
                                                            : sum_wide[TOT_W-1:0];

  // ---------------------------------------------------------------------------
  // Set state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      total     <= '0;
      prev_x    <= '0;
      prev_y    <= '0;
      one_pt    <= 1'b0;
    end else if (state == ppl_pkg::ST_LOAD) begin
      one_pt <= !have_prev;
      if (!have_prev && !last_r) begin
        prev_x    <= x_r;
        prev_y    <= y_r;
        have_prev <= 1'b1;
        total     <= '0;
      end
    end else if (emit_fire) begin
      if (last_r) begin
        have_prev <= 1'b0;
        total     <= '0;
        prev_x    <= '0;
        prev_y    <= '0;
      end else begin
        prev_x <= x_r;
        prev_y <= y_r;
        total  <= sum_sat;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      res.segment_length <= one_pt ? '0 : seg_sat;
      res.total_length   <= one_pt ? '0 : sum_sat;
      res.set_done       <= last_r;
    end
  end

endmodule

`default_nettype wire

@@ src/ppl_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, one root bit per cycle.
module ppl_sqrt #(
  parameter int ROOT_BITS = ppl_pkg::COORD_BITS_DEF + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [2*ROOT_BITS-1:0]   radicand,
  output logic                          done,
  output logic      [ROOT_BITS-1:0]     root
);

  localparam int RW = ROOT_BITS;
  localparam int CW = $clog2(RW);

  logic [2*RW-1:0] rad;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;

  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            ge;

  assign rem_sh = {rem[RW:0], rad[2*RW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;
  assign done   = busy && (cnt == CW'(RW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[2*RW-3:0], 2'b00};
      rem  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
      root <= {root[RW-2:0], ge};
      cnt  <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ src/ppl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ppl_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             pt_valid,
  input wire logic             pt_stall,
  input wire ppl_pkg::point_t  pt,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire ppl_pkg::result_t res
);

  // a held result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // nothing leaves straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // one point at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_stall |=> pt_stall)
    else $error("point taken while busy");

  // total already includes this segment
  a_total_ge_seg: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.total_length >= 32'(res.segment_length)))
    else $error("total below segment");

endmodule

bind polyline_path_length ppl_checker u_ppl_checker (
  .clk       (clk),
  .rst       (rst),
  .pt_valid  (pt_valid),
  .pt_stall  (pt_stall),
  .pt        (pt),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire
